// ----- sv/bawd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bawd_pkg;

    // Row geometry
    localparam int MAX_ROW_WORDS = 64;
    localparam int COL_W         = $clog2(MAX_ROW_WORDS);
    localparam int ROW_W         = 7;
    localparam int WORD_W        = 16;

    // Register map, index = paddr[4:2]
    localparam int ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_MINTERM    = 3'd0,
        REG_SHIFT_A    = 3'd1,
        REG_SHIFT_B    = 3'd2,
        REG_DESCENDING = 3'd3,
        REG_FIRST_MASK = 3'd4,
        REG_LAST_MASK  = 3'd5,
        REG_ROW_WORDS  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]        minterm;
        logic [3:0]        shift_a;
        logic [3:0]        shift_b;
        logic              descending;
        logic [WORD_W-1:0] first_word_mask;
        logic [WORD_W-1:0] last_word_mask;
        logic [ROW_W-1:0]  row_words;
    } cfg_t;

    // Carried row state
    typedef struct packed {
        logic [WORD_W-1:0] previous_a;
        logic [WORD_W-1:0] previous_b;
        logic [COL_W-1:0]  column_index;
        logic              zero_flag;
    } row_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_d;
        logic              all_zero;
        logic              row_end;
    } unit_res_t;

    // Funnel shift of the previous and current word of a channel
    function automatic logic [WORD_W-1:0] barrel(
        input logic [WORD_W-1:0] prev,
        input logic [WORD_W-1:0] cur,
        input logic [3:0]        sh,
        input logic              left
    );
        logic [2*WORD_W-1:0] right_cat;
        logic [2*WORD_W-1:0] left_cat;
        right_cat = {prev, cur} >> sh;
        left_cat  = {cur, prev} << sh;
        if (left)
            barrel = left_cat[2*WORD_W-1:WORD_W];
        else
            barrel = right_cat[WORD_W-1:0];
    endfunction

    // Each D bit is the minterm bit picked by {a,b,c}
    function automatic logic [WORD_W-1:0] combine(
        input logic [7:0]        mt,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c
    );
        logic [WORD_W-1:0] d;
        d = '0;
        for (int i = 0; i < WORD_W; i++)
            d[i] = mt[{a[i], b[i], c[i]}];
        combine = d;
    endfunction

endpackage

`default_nettype wire

// ----- sv/blitter_area_word_datapath_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A word accepted on s_tdata passes through the input register, then the combinational
// word unit into the result register that drives m_tvalid. One word per cycle while
// m_tready is high; the input register and the result register each hold one word.
// Reset (rst_n low, asynchronous): both stages empty, row state cleared with the zero
// flag set, registers at minterm 0, shifts 0, ascending, masks 0xFFFF, row width 1.
module blitter_area_word_datapath_core
    import bawd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // word_a, word_b, word_c
    input  wire logic [0:0]        s_tuser,   // blit_start
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // word_d
    output logic [0:0]             m_tuser,   // all_zero
    output logic                   m_tlast    // row_end
);

    cfg_t              cfg_reg;
    row_state_t        state_reg;
    row_state_t        state_next;
    unit_res_t         res;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_a_reg;
    logic [WORD_W-1:0] in_b_reg;
    logic [WORD_W-1:0] in_c_reg;
    logic              in_start_reg;
    logic              advance;

    logic              out_valid_reg;
    unit_res_t         out_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minterm         <= '0;
            cfg_reg.shift_a         <= '0;
            cfg_reg.shift_b         <= '0;
            cfg_reg.descending      <= 1'b0;
            cfg_reg.first_word_mask <= '1;
            cfg_reg.last_word_mask  <= '1;
            cfg_reg.row_words       <= ROW_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MINTERM:    cfg_reg.minterm         <= pwdata[7:0];
                REG_SHIFT_A:    cfg_reg.shift_a         <= pwdata[3:0];
                REG_SHIFT_B:    cfg_reg.shift_b         <= pwdata[3:0];
                REG_DESCENDING: cfg_reg.descending      <= pwdata[0];
                REG_FIRST_MASK: cfg_reg.first_word_mask <= pwdata[WORD_W-1:0];
                REG_LAST_MASK:  cfg_reg.last_word_mask  <= pwdata[WORD_W-1:0];
                REG_ROW_WORDS:  cfg_reg.row_words       <= pwdata[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_MINTERM:    prdata = 32'(cfg_reg.minterm);
            REG_SHIFT_A:    prdata = 32'(cfg_reg.shift_a);
            REG_SHIFT_B:    prdata = 32'(cfg_reg.shift_b);
            REG_DESCENDING: prdata = 32'(cfg_reg.descending);
            REG_FIRST_MASK: prdata = 32'(cfg_reg.first_word_mask);
            REG_LAST_MASK:  prdata = 32'(cfg_reg.last_word_mask);
            REG_ROW_WORDS:  prdata = 32'(cfg_reg.row_words);
            default:        prdata = '0;
        endcase
    end

    // Pipeline control: the input stage moves on when the result slot is free
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_a_reg     <= s_tdata[15:0];
            in_b_reg     <= s_tdata[31:16];
            in_c_reg     <= s_tdata[47:32];
            in_start_reg <= s_tuser[0];
        end
    end

    bawd_word_unit u_word_unit (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .word_a     (in_a_reg),
        .word_b     (in_b_reg),
        .word_c     (in_c_reg),
        .blit_start (in_start_reg),
        .res        (res),
        .state_next (state_next)
    );

    // Row state updates as each word passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.previous_a   <= '0;
            state_reg.previous_b   <= '0;
            state_reg.column_index <= '0;
            state_reg.zero_flag    <= 1'b1;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.word_d;
    assign m_tuser[0] = out_reg.all_zero;
    assign m_tlast    = out_reg.row_end;

    // A held input word stays until it moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage lost a word");

    // The last word of a row wraps the column
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.row_end |=> state_reg.column_index == '0)
        else $error("column did not wrap at row end");

    // all_zero can only be reported with a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("all_zero set with nonzero word_d");

    // Once cleared, the zero flag stays cleared until a new blit
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_start_reg && !state_reg.zero_flag |=> !state_reg.zero_flag)
        else $error("zero flag set again within a blit");

endmodule

`default_nettype wire

// ----- sv/bawd_word_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bawd_word_unit
    import bawd_pkg::*;
(
    input  wire cfg_t              cfg,
    input  wire row_state_t        state,
    input  wire logic [WORD_W-1:0] word_a,
    input  wire logic [WORD_W-1:0] word_b,
    input  wire logic [WORD_W-1:0] word_c,
    input  wire logic              blit_start,
    output unit_res_t              res,
    output row_state_t             state_next
);

    logic [ROW_W-1:0]  width;
    logic [COL_W-1:0]  col;
    logic              first;
    logic              last;
    logic [WORD_W-1:0] prev_a;
    logic [WORD_W-1:0] prev_b;
    logic [WORD_W-1:0] masked_a;
    logic [WORD_W-1:0] sa;
    logic [WORD_W-1:0] sb;
    logic [WORD_W-1:0] d;
    logic              flag;

    // Effective row width, clamped to 1..MAX_ROW_WORDS
    always_comb
    begin
        if (cfg.row_words == '0)
            width = ROW_W'(1);
        else if (cfg.row_words > ROW_W'(MAX_ROW_WORDS))
            width = ROW_W'(MAX_ROW_WORDS);
        else
            width = cfg.row_words;
    end

    // Column position; a start restarts the row
    assign col   = blit_start ? '0 : state.column_index;
    assign first = (col == '0);
    assign last  = ((ROW_W'(col) + ROW_W'(1)) >= width);

    // Previous words are cleared at the start of each row
    assign prev_a = first ? '0 : state.previous_a;
    assign prev_b = first ? '0 : state.previous_b;

    // Edge masks on A
    always_comb
    begin
        masked_a = word_a;
        if (first)
            masked_a = masked_a & cfg.first_word_mask;
        if (last)
            masked_a = masked_a & cfg.last_word_mask;
    end

    assign sa = barrel(prev_a, masked_a, cfg.shift_a, cfg.descending);
    assign sb = barrel(prev_b, word_b, cfg.shift_b, cfg.descending);
    assign d  = combine(cfg.minterm, sa, sb, word_c);

    // Sticky zero flag across the blit
    assign flag = (blit_start | state.zero_flag) & (d == '0);

    assign res.word_d   = d;
    assign res.all_zero = flag;
    assign res.row_end  = last;

    assign state_next.previous_a   = masked_a;
    assign state_next.previous_b   = word_b;
    assign state_next.column_index = last ? '0 : col + COL_W'(1);
    assign state_next.zero_flag    = flag;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bawd_pkg::*;

    // Index with no register behind it; writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int RANDOM_WORDS = 1600;
    localparam int PLAN_LEN = 46;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // One directed step: a register write (value in a) or one column word
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  sel;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        start;
        logic        typed;
        logic [15:0] want_d;
        logic        want_z;
        logic        want_l;
    } plan_row_t;

    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        // reset registers: minterm 0, one-word rows
        '{ROW_WORD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
        '{ROW_REG, REG_MINTERM, 16'h00FF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b1},
        '{ROW_WORD, '0, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1},
        // D = A, both masks land on a one-word row
        '{ROW_REG, REG_MINTERM, 16'h00F0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_FIRST_MASK, 16'h00FF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_LAST_MASK, 16'hFF0F, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h000F, 1'b0, 1'b1},
        // zero row width behaves as one word
        '{ROW_REG, REG_ROW_WORDS, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'h000F, 1'b0, 1'b1},
        // masks fully closed: D zero, flag set again by start
        '{ROW_REG, REG_FIRST_MASK, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_LAST_MASK, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
        // three-word rows, ascending shifts
        '{ROW_REG, REG_ROW_WORDS, 16'h0003, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_FIRST_MASK, 16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_LAST_MASK, 16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_SHIFT_A, 16'h0004, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_SHIFT_B, 16'h000F, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_MINTERM, 16'h00CA, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h8001, 16'h4002, 16'hF00F, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'h0000, 16'h1234, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0F0F, 16'hF0F0, 16'hAAAA, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h1111, 16'h2222, 16'h3333, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        // descending mode, widest A shift
        '{ROW_REG, REG_DESCENDING, 16'h0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_SHIFT_A, 16'h000F, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_SHIFT_B, 16'h0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h8000, 16'h0001, 16'h5555, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h00FF, 16'hFF00, 16'h0000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        // oversized width clips to the maximum, stop mid-row
        '{ROW_REG, REG_ROW_WORDS, 16'h007F, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_MINTERM, 16'h0096, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hC3C3, 16'h3C3C, 16'h0F0F, 1'b1, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0001, 16'h8000, 16'hFFFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hABCD, 16'h1234, 16'h0000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h7FFE, 16'h8001, 16'h1248, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        // width shrinks under the current column: next word closes the row
        '{ROW_REG, REG_ROW_WORDS, 16'h0002, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h1357, 16'h2468, 16'h9BDF, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        // unmapped index must not disturb anything
        '{ROW_REG, REG_MINTERM, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_SPARE, 16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_REG, REG_ROW_WORDS, 16'h0041, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{ROW_WORD, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{ROW_REG, REG_MINTERM, 16'h0001, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0}
    };

    localparam logic [7:0] MT_PICKS [0:8] = '{
        8'h00, 8'hFF, 8'hF0, 8'hCC, 8'hAA, 8'hCA, 8'h96, 8'h80, 8'h01
    };

    // DUT connections; the inputs are all driven from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // word_a, word_b, word_c
    logic [0:0]  s_tuser  = '0;   // blit_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // word_d
    logic [0:0]  m_tuser;         // all_zero
    logic        m_tlast;

    // Shadow registers and row state of the predictor
    cfg_t        shadow;
    logic [15:0] prev_a;
    logic [15:0] prev_b;
    int          col_pos;
    logic        zero_flag;

    // Expected destination words, oldest first
    unit_res_t   pending_dest_words [$];

    // Typed expectation riding along with the word on the bus
    logic        typed_pending = 1'b0;
    unit_res_t   typed_value   = '0;

    int          mismatch_count = 0;
    int          words_sent     = 0;
    int          burst_left     = 0;
    int          tx_gap_max     = 0;
    int          rx_mode        = 0;
    logic [15:0] rx_pattern     = 16'b1110_0110_1011_0001;

    blitter_area_word_datapath_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Funnel shift: previous word fills high bits going right, low bits going left
    function automatic logic [15:0] funnel(input logic [15:0] prev, input logic [15:0] cur,
                                           input logic [3:0] sh, input logic left);
        logic [15:0] r;
        r = cur;
        if (sh != 4'd0) begin
            if (left)
                r = (cur << sh) | (prev >> (5'd16 - {1'b0, sh}));
            else
                r = (cur >> sh) | (prev << (5'd16 - {1'b0, sh}));
        end
        return r;
    endfunction

    // Sum of the minterm products selected by mt
    function automatic logic [15:0] minterm_mix(input logic [7:0] mt, input logic [15:0] a,
                                                input logic [15:0] b, input logic [15:0] c);
        logic [15:0] d;
        int t;
        d = '0;
        for (t = 0; t < 8; t++) begin
            if (mt[t])
                d |= (t[2] ? a : ~a) & (t[1] ? b : ~b) & (t[0] ? c : ~c);
        end
        return d;
    endfunction

    // Destination word of one column; advances the row state
    function automatic unit_res_t blit_column(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic start);
        int          span;
        logic        at_end;
        logic [15:0] a_m;
        logic [15:0] sa;
        logic [15:0] sb;
        unit_res_t   r;
        span = int'(shadow.row_words);
        if (span == 0)
            span = 1;
        if (span > MAX_ROW_WORDS)
            span = MAX_ROW_WORDS;
        if (start) begin
            zero_flag = 1'b1;
            col_pos   = 0;
        end
        if (col_pos == 0) begin
            prev_a = '0;
            prev_b = '0;
        end
        at_end = (col_pos + 1) >= span;
        a_m = a;
        if (col_pos == 0)
            a_m &= shadow.first_word_mask;
        if (at_end)
            a_m &= shadow.last_word_mask;
        sa = funnel(prev_a, a_m, shadow.shift_a, shadow.descending);
        sb = funnel(prev_b, b, shadow.shift_b, shadow.descending);
        prev_a = a_m;
        prev_b = b;
        r.word_d = minterm_mix(shadow.minterm, sa, sb, c);
        if (r.word_d != 16'h0)
            zero_flag = 1'b0;
        col_pos    = at_end ? 0 : col_pos + 1;
        r.all_zero = zero_flag;
        r.row_end  = at_end;
        return r;
    endfunction

    function automatic logic [15:0] pick_word(input int mode);
        logic [15:0] w;
        case (mode)
            1:       w = 16'($urandom) & 16'($urandom) & 16'($urandom);
            2:       w = ($urandom_range(0, 3) != 0) ? 16'h0 : 16'($urandom);
            default: w = 16'($urandom);
        endcase
        if ($urandom_range(0, 15) == 0)
            w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return w;
    endfunction

    task automatic report_mismatch(input unit_res_t want, input unit_res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: word_d exp %h got %h, all_zero exp %b got %b, row_end exp %b got %b",
                     $realtime, want.word_d, got.word_d, want.all_zero, got.all_zero,
                     want.row_end, got.row_end);
    endtask

    // Input transfers feed the predictor, output transfers are checked
    always @(posedge clk) begin : monitor
        unit_res_t seen;
        unit_res_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                seen = blit_column(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tuser[0]);
                pending_dest_words.push_back(typed_pending ? typed_value : seen);
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tdata, m_tuser[0], m_tlast};
                if (pending_dest_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result %h with nothing pending", $realtime, m_tdata);
                end else begin
                    want = pending_dest_words.pop_front();
                    if (seen.word_d !== want.word_d || seen.all_zero !== want.all_zero ||
                        seen.row_end !== want.row_end)
                        report_mismatch(want, seen);
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk) begin
        rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= rx_pattern[15];
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Offer one column word in bursts, return once it is transferred
    task automatic push_word(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                             input logic start, input logic typed, input unit_res_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid      <= 1'b1;
        s_tdata       <= {c, b, a};
        s_tuser       <= start;
        typed_pending <= typed;
        typed_value   <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stop the stream and let the pipeline empty
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_dest_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [15:0] value);
        settle_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_MINTERM:    shadow.minterm         = value[7:0];
            REG_SHIFT_A:    shadow.shift_a         = value[3:0];
            REG_SHIFT_B:    shadow.shift_b         = value[3:0];
            REG_DESCENDING: shadow.descending      = value[0];
            REG_FIRST_MASK: shadow.first_word_mask = value;
            REG_LAST_MASK:  shadow.last_word_mask  = value;
            REG_ROW_WORDS:  shadow.row_words       = value[6:0];
            default: ;
        endcase
    endtask

    // Safety net against a hung handshake
    initial begin
        #5_000_000;
        $display("[blitter_area_word_datapath_core] ERROR");
        $finish;
    end

    initial begin
        int i;
        int k;
        int n;
        int j;
        int blit_len;
        int data_mode;
        int phase;
        int drain_wait;
        logic st;

        shadow.minterm         = 8'h00;
        shadow.shift_a         = 4'h0;
        shadow.shift_b         = 4'h0;
        shadow.descending      = 1'b0;
        shadow.first_word_mask = 16'hFFFF;
        shadow.last_word_mask  = 16'hFFFF;
        shadow.row_words       = 7'd1;
        prev_a    = '0;
        prev_b    = '0;
        col_pos   = 0;
        zero_flag = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        tx_gap_max = 2;
        rx_mode    = 1;
        for (i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_REG)
                write_reg(PLAN[i].sel, PLAN[i].a);
            else
                push_word(PLAN[i].a, PLAN[i].b, PLAN[i].c, PLAN[i].start, PLAN[i].typed,
                          {PLAN[i].want_d, PLAN[i].want_z, PLAN[i].want_l});
        end

        // Random phases: new settings, then blits of random length
        phase = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_MINTERM, {8'h0, $urandom_range(0, 1) ? 8'($urandom)
                                                : MT_PICKS[$urandom_range(0, 8)]});
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_SHIFT_A, ($urandom_range(0, 3) == 0)
                                       ? ($urandom_range(0, 1) ? 16'hF : 16'h0)
                                       : 16'($urandom_range(0, 15)));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_SHIFT_B, ($urandom_range(0, 3) == 0)
                                       ? ($urandom_range(0, 1) ? 16'hF : 16'h0)
                                       : 16'($urandom_range(0, 15)));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_DESCENDING, 16'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_FIRST_MASK, ($urandom_range(0, 3) == 0)
                                          ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                          : 16'($urandom));
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_LAST_MASK, ($urandom_range(0, 3) == 0)
                                         ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                         : 16'($urandom));
            if (phase == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_ROW_WORDS, 16'd0);
                    1:       write_reg(REG_ROW_WORDS, 16'd64);
                    2:       write_reg(REG_ROW_WORDS, 16'd127);
                    3:       write_reg(REG_ROW_WORDS, 16'($urandom_range(0, 127)));
                    default: write_reg(REG_ROW_WORDS, 16'($urandom_range(1, 8)));
                endcase
            end

            case ($urandom_range(0, 2))
                0:       tx_gap_max = 0;
                1:       tx_gap_max = 2;
                default: tx_gap_max = 8;
            endcase
            rx_mode   = $urandom_range(0, 3);
            data_mode = $urandom_range(0, 2);

            n = $urandom_range(10, 80);
            k = 0;
            while (k < n) begin
                blit_len = $urandom_range(1, 24);
                for (j = 0; j < blit_len && k < n; j++) begin
                    // mostly well-formed blits, with a stray or missing start now and then
                    st = (j == 0);
                    if ($urandom_range(0, 19) == 0)
                        st = ~st;
                    push_word(pick_word(data_mode), pick_word(data_mode), pick_word(data_mode),
                              st, 1'b0, '0);
                    k++;
                end
            end
            phase++;
        end

        // Drain, then allow the pipeline latency before judging
        s_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_dest_words.size() != 0 && drain_wait < 2000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (4) @(posedge clk);
        mismatch_count += pending_dest_words.size();

        if (mismatch_count == 0)
            $display("[blitter_area_word_datapath_core] OK");
        else
            $display("[blitter_area_word_datapath_core] ERROR");
        $finish;
    end

endmodule
